### hw/rtl/sds_pkg.sv
// Shared constants, field widths and control/status types for the SSTF disk scheduler.
// Used by sds_ctrl, sds_datapath and sstf_disk_scheduler; depends on nothing.

package sds_pkg;

	localparam int MAX_REQUESTS = 16;
	localparam int CYL_W = 16;
	localparam int TOT_W = 20;
	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int KIND_W = 2;
	localparam int FLAG_W = 2;
	localparam int OUT_DATA_W = ((2 * CYL_W + TOT_W + 7) / 8) * 8;

	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RUN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic load_req;
		logic clear_set;
		logic start_run;
		logic scan_step;
		logic emit;
		logic emit_empty;
	} sds_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic step_last;
		logic out_free;
	} sds_sts_t;

endpackage

### hw/rtl/sds_ctrl.sv
// Controller state machine of the SSTF disk scheduler.
// Depends on sds_pkg; drives the command struct of sds_datapath from its status struct.

module sds_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [sds_pkg::KIND_W-1:0]   in_kind,
	output logic                         in_ready,
	input  sds_pkg::sds_sts_t            sts,
	output sds_pkg::sds_cmd_t            cmd
);
	import sds_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_EMPTY = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_kind)
						KIND_LOAD: cmd.load_req = 1'b1;
						KIND_CLEAR: cmd.clear_set = 1'b1;
						KIND_RUN: begin
							cmd.start_run = 1'b1;
							state_d = sts.count_zero ? ST_EMPTY : ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = sts.step_last ? ST_IDLE : ST_SCAN;
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit_empty = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.emit_empty) |-> sts.out_free)
		else $error("Result issued while the output register is occupied.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_last) |=> (state_q == ST_EMIT))
		else $error("Finished scan did not move to the emit state.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && sts.out_free && !sts.step_last) |=> (state_q == ST_SCAN))
		else $error("Run ended before all loaded requests were served.");

endmodule

### hw/rtl/sds_datapath.sv
// Datapath of the SSTF disk scheduler: request store, served marks, nearest-request scan
// and the output register. Depends on sds_pkg; commanded by sds_ctrl.

module sds_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [sds_pkg::CYL_W-1:0]       in_cyl,
	input  sds_pkg::sds_cmd_t               cmd,
	output sds_pkg::sds_sts_t               sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [sds_pkg::CYL_W-1:0]       out_cyl,
	output logic [sds_pkg::CYL_W-1:0]       out_dist,
	output logic [sds_pkg::TOT_W-1:0]       out_total,
	output logic                            out_last,
	output logic                            out_empty,
	output logic                            out_overflow
);
	import sds_pkg::*;

	logic [CYL_W-1:0]        store_q [MAX_REQUESTS];
	logic [MAX_REQUESTS-1:0] served_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        steps_q;
	logic [IDX_W-1:0]        scan_idx_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic [CYL_W-1:0]        best_cyl_q;
	logic [CYL_W-1:0]        best_dist_q;
	logic                    found_q;
	logic [CYL_W-1:0]        head_q;
	logic [TOT_W-1:0]        total_q;
	logic                    dropped_q;
	logic                    out_valid_q;

	logic [CYL_W-1:0] cand_cyl;
	logic [CYL_W-1:0] cand_dist;
	logic             take;
	logic [TOT_W-1:0] total_next;

	assign cand_cyl = store_q[scan_idx_q];
	assign cand_dist = (cand_cyl >= head_q) ? (cand_cyl - head_q) : (head_q - cand_cyl);
	assign take = !served_q[scan_idx_q] && (!found_q || (cand_dist < best_dist_q));
	assign total_next = total_q + TOT_W'(best_dist_q);

	assign sts.count_zero = (count_q == '0);
	assign sts.scan_last = ((CNT_W'(scan_idx_q) + CNT_W'(1)) == count_q);
	assign sts.step_last = ((steps_q + CNT_W'(1)) == count_q);
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_req && (count_q < CNT_W'(MAX_REQUESTS))) begin
			store_q[count_q[IDX_W-1:0]] <= in_cyl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			served_q <= '0;
			count_q <= '0;
			steps_q <= '0;
			scan_idx_q <= '0;
			found_q <= 1'b0;
			head_q <= '0;
			total_q <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				if (count_q < CNT_W'(MAX_REQUESTS)) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.clear_set) begin
				count_q <= '0;
				served_q <= '0;
				dropped_q <= 1'b0;
			end
			if (cmd.start_run) begin
				served_q <= '0;
				head_q <= in_cyl;
				total_q <= '0;
				steps_q <= '0;
				scan_idx_q <= '0;
				found_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				served_q[best_idx_q] <= 1'b1;
				head_q <= best_cyl_q;
				total_q <= total_next;
				steps_q <= steps_q + CNT_W'(1);
				scan_idx_q <= '0;
				found_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && take) begin
			best_idx_q <= scan_idx_q;
			best_cyl_q <= cand_cyl;
			best_dist_q <= cand_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.emit_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_cyl <= best_cyl_q;
			out_dist <= best_dist_q;
			out_total <= total_next;
			out_last <= sts.step_last;
			out_empty <= 1'b0;
			out_overflow <= dropped_q;
		end else if (cmd.emit_empty) begin
			out_cyl <= '0;
			out_dist <= '0;
			out_total <= '0;
			out_last <= 1'b1;
			out_empty <= 1'b1;
			out_overflow <= dropped_q;
		end
	end

	assign out_valid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_REQUESTS))
		else $error("Request count exceeds the store depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (found_q && !served_q[best_idx_q]))
		else $error("Emitted request was not found or already served.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_empty) |-> (out_last && out_total == '0 && out_dist == '0))
		else $error("Empty-run word carries nonzero data.");

endmodule

### hw/rtl/sstf_disk_scheduler.sv
// Top level of the shortest-seek-time-first disk scheduler.
// Depends on sds_pkg; instantiates sds_ctrl and sds_datapath.
//
// Input words on the s_ channel carry a kind in s_tuser and a cylinder in s_tdata. A load
// word stores a request (dropped and flagged as overflow once the store is full), a clear
// word empties the set, and a run word gives the starting head position. A run over n
// loaded requests emits n output words, nearest first with ties going to the earliest
// load, the final one marked by m_tlast; a run over an empty set emits one word with the
// empty flag set. Each output word is found by a scan over all loaded requests in the
// store, then written to the output register. Only one word is worked on at a time:
// s_tready is high only while the controller is idle, which it may be while the last
// result still waits in the output register. A stall on m_tready holds the result, and
// the run waits before writing its next output word until the result is taken.
// Reset empties the set, clears the overflow flag, puts the head at zero and drops any
// result not yet taken.

module sstf_disk_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sds_pkg::CYL_W-1:0]           s_tdata,  // [15:0] cylinder
	input  logic [sds_pkg::KIND_W-1:0]          s_tuser,  // [1:0] kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [15:0] served_cylinder, [31:16] seek_distance, [51:32] total_seek, [55:52] zero
	output logic [sds_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                m_tlast,
	output logic [sds_pkg::FLAG_W-1:0]          m_tuser   // [0] empty_res, [1] overflow
);
	import sds_pkg::*;

	sds_cmd_t         cmd;
	sds_sts_t         sts;
	logic [CYL_W-1:0] out_cyl;
	logic [CYL_W-1:0] out_dist;
	logic [TOT_W-1:0] out_total;
	logic             out_empty;
	logic             out_overflow;

	sds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sds_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_cyl       (s_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_cyl      (out_cyl),
		.out_dist     (out_dist),
		.out_total    (out_total),
		.out_last     (m_tlast),
		.out_empty    (out_empty),
		.out_overflow (out_overflow)
	);

	assign m_tdata = OUT_DATA_W'({out_total, out_dist, out_cyl});
	assign m_tuser = {out_overflow, out_empty};

endmodule

### tb/sstf_disk_scheduler_tb.sv
// Self-checking testbench for sstf_disk_scheduler: directed and random load, run and clear words
// under random sender gaps and receiver stalls. Depends on sds_pkg and the scheduler RTL only.
// A scoreboard class predicts every served word and checks the output stream against it.

module sstf_disk_scheduler_tb;
	import sds_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [CYL_W-1:0] cylinder;
		logic [CYL_W-1:0] distance;
		logic [TOT_W-1:0] total;
		logic             last;
		logic             empty;
		logic             overflow;
	} serve_t;

	class seek_order_checker;
		logic [CYL_W-1:0] cyl_store [MAX_REQUESTS];
		int               loaded = 0;
		logic             dropped = 1'b0;
		serve_t           due [$];
		int               mismatches = 0;
		int               checked = 0;

		function void note_word(logic [KIND_W-1:0] kind, logic [CYL_W-1:0] cyl);
			logic [MAX_REQUESTS-1:0] taken;
			logic [CYL_W-1:0]        head;
			logic [TOT_W:0]          sum;
			int                      best;
			int                      best_d;
			int                      d;
			serve_t                  s;
			case (kind)
				KIND_LOAD: begin
					if (loaded < MAX_REQUESTS) begin
						cyl_store[loaded] = cyl;
						loaded++;
					end else begin
						dropped = 1'b1;
					end
				end
				KIND_CLEAR: begin
					loaded = 0;
					dropped = 1'b0;
				end
				KIND_RUN: begin
					taken = '0;
					head = cyl;
					sum = '0;
					if (loaded == 0) begin
						s.cylinder = '0;
						s.distance = '0;
						s.total = '0;
						s.last = 1'b1;
						s.empty = 1'b1;
						s.overflow = dropped;
						due = {due, s};
					end
					for (int step = 0; step < loaded; step++) begin
						best = -1;
						best_d = 0;
						for (int j = 0; j < loaded; j++) begin
							d = int'(cyl_store[j]) - int'(head);
							if (d < 0)
								d = -d;
							if (!taken[j] && (best < 0 || d < best_d)) begin
								best = j;
								best_d = d;
							end
						end
						taken[best] = 1'b1;
						head = cyl_store[best];
						sum = sum + (TOT_W+1)'(best_d);
						s.cylinder = head;
						s.distance = CYL_W'(best_d);
						s.total = sum[TOT_W-1:0];
						s.last = (step == loaded - 1);
						s.empty = 1'b0;
						s.overflow = dropped;
						due = {due, s};
					end
				end
				default: begin
				end
			endcase
		endfunction

		function void check_field(string field, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH in word %0d, %s: expected %0h, got %0h",
						checked, field, want, got);
			end
		endfunction

		function void check_served(logic [OUT_DATA_W-1:0] data, logic last,
			logic [FLAG_W-1:0] flags);
			serve_t s;
			checked++;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("MISMATCH: word %0d (data %0h) arrived with nothing pending",
						checked, data);
				return;
			end
			s = due.pop_front();
			check_field("served_cylinder", 64'(s.cylinder), 64'(data[CYL_W-1:0]));
			check_field("seek_distance", 64'(s.distance), 64'(data[2*CYL_W-1:CYL_W]));
			check_field("total_seek", 64'(s.total), 64'(data[2*CYL_W+TOT_W-1:2*CYL_W]));
			check_field("padding", 64'(0), 64'(data[OUT_DATA_W-1:2*CYL_W+TOT_W]));
			check_field("last", 64'(s.last), 64'(last));
			check_field("empty_res", 64'(s.empty), 64'(flags[0]));
			check_field("overflow", 64'(s.overflow), 64'(flags[1]));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [CYL_W-1:0]      s_tdata = '0;
	logic [KIND_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic [FLAG_W-1:0]     m_tuser;

	seek_order_checker chk;
	int                send_idle = 0;
	int                recv_stall = 0;
	int                cycles = 0;
	int                kind_seen [4] = '{0, 0, 0, 0};

	sstf_disk_scheduler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			chk.check_served(m_tdata, m_tlast, m_tuser);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Run stopped by the cycle limit after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [CYL_W-1:0] cyl);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= cyl;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chk.note_word(kind, cyl);
		kind_seen[kind]++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (chk.due.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic [CYL_W-1:0] pick_cylinder();
		case ($urandom_range(3))
			0: return CYL_W'($urandom_range(15));
			1: return $urandom_range(1) ? {CYL_W{1'b1}} : {CYL_W{1'b0}};
			default: return CYL_W'($urandom());
		endcase
	endfunction

	// Mostly well-formed batches: an optional clear, a few loads (now and then enough to
	// overflow the store), then one or two runs. Unused kinds are mixed in as noise.
	task automatic random_phase(input int items);
		int sent;
		int n;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(99) < 50) begin
				send_word(KIND_CLEAR, CYL_W'($urandom()));
				sent++;
			end
			n = ($urandom_range(9) == 0) ? $urandom_range(MAX_REQUESTS + 3) : $urandom_range(6);
			repeat (n) begin
				send_word(KIND_LOAD, pick_cylinder());
				sent++;
			end
			if ($urandom_range(9) == 0)
				send_word(KIND_UNUSED, CYL_W'($urandom()));
			repeat ($urandom_range(1, 2)) begin
				send_word(KIND_RUN, pick_cylinder());
				sent++;
			end
		end
	endtask

	initial begin
		chk = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(KIND_RUN, 16'hFFFF);
		send_word(KIND_UNUSED, 16'h5555);
		send_word(KIND_LOAD, 16'h0000);
		send_word(KIND_LOAD, 16'hFFFF);
		send_word(KIND_RUN, 16'h8000);
		send_word(KIND_RUN, 16'h0000);
		send_word(KIND_CLEAR, 16'hAAAA);
		// Equal distances on both sides of the head go to the earlier load.
		send_word(KIND_LOAD, 16'd110);
		send_word(KIND_LOAD, 16'd90);
		send_word(KIND_LOAD, 16'd90);
		send_word(KIND_RUN, 16'd100);
		for (int i = 0; i < MAX_REQUESTS - 3; i++)
			send_word(KIND_LOAD, i[0] ? 16'hFFFF : 16'h0000);
		send_word(KIND_LOAD, 16'h1234);
		send_word(KIND_RUN, 16'h7FFF);
		send_word(KIND_CLEAR, 16'h0000);
		send_word(KIND_RUN, 16'h0001);
		wait_drained();

		random_phase(75);
		wait_drained();
		send_idle = 70;
		random_phase(75);
		wait_drained();
		send_idle = 0;
		recv_stall = 70;
		random_phase(75);
		wait_drained();
		send_idle = 18;
		recv_stall = 18;
		random_phase(75);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d loads, %0d runs, %0d clears and %0d unused-kind words;",
			kind_seen[KIND_LOAD], kind_seen[KIND_RUN], kind_seen[KIND_CLEAR],
			kind_seen[KIND_UNUSED]);
		$display("checked %0d served words in %0d cycles.", chk.checked, cycles);
		if (chk.mismatches == 0 && chk.due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
hw/rtl/sds_pkg.sv
hw/rtl/sds_ctrl.sv
hw/rtl/sds_datapath.sv
hw/rtl/sstf_disk_scheduler.sv
tb/sstf_disk_scheduler_tb.sv
